// File: rtl/tmcb_pkg.sv
// Shared constants and helper functions for the text-mode cell buffer.
package tmcb_pkg;

  // Default geometry
  localparam int ROWS_DEF         = 48;
  localparam int COLS_DEF         = 106;
  localparam int VISIBLE_ROWS_DEF = 48;

  // Bus address of the scroll register
  localparam logic [15:0] SCROLL_ADDR = 16'h3001;

  // Transaction kinds carried in tuser
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Cell contents after reset: space, bright white on black
  localparam logic [7:0] RESET_GLYPH = 8'h20;
  localparam logic [7:0] RESET_ATTR  = 8'h0F;

  // Printable character range
  localparam logic [7:0] GLYPH_MIN     = 8'd32;
  localparam logic [7:0] GLYPH_INVALID = 8'hFF;
  localparam logic [7:0] GLYPH_EMPTY   = 8'h00;

  // Attribute nibble: bit 0 red, bit 1 green, bit 2 blue, bit 3 bright
  localparam int ATTR_RED    = 0;
  localparam int ATTR_GREEN  = 1;
  localparam int ATTR_BLUE   = 2;
  localparam int ATTR_BRIGHT = 3;

  localparam logic [7:0] LEVEL_OFF    = 8'd0;
  localparam logic [7:0] LEVEL_NORMAL = 8'd128;
  localparam logic [7:0] LEVEL_BRIGHT = 8'd255;

  // Non-printable characters are stored as the empty glyph; the attribute is kept
  function automatic logic [7:0] clean_glyph(input logic [7:0] ch);
    logic [7:0] res;
    res = ch;
    if (ch < GLYPH_MIN || ch == GLYPH_INVALID) begin
      res = GLYPH_EMPTY;
    end
    return res;
  endfunction

  // Expand one color component of an attribute nibble to 8 bits
  function automatic logic [7:0] level(input logic [3:0] attr, input int comp);
    logic [7:0] res;
    res = LEVEL_OFF;
    if (attr[comp]) begin
      res = attr[ATTR_BRIGHT] ? LEVEL_BRIGHT : LEVEL_NORMAL;
    end
    return res;
  endfunction

endpackage

// File: rtl/tmcb_ram.sv
// Generic single-port RAM with registered read data.
module tmcb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 5088
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One access per enabled cycle: write, or read into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/tmcb_mod.sv
// Three-stage pipelined remainder by a constant divisor (reciprocal multiply).
module tmcb_mod #(
  parameter int IN_W = 16,
  parameter int DIV  = 48
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IN_W-1:0] x,
  output logic [IN_W-1:0] r
);

  // Floor reciprocal: quotient estimate is exact or one low
  localparam int          SHIFT  = IN_W + $clog2(DIV);
  localparam int          PROD_W = SHIFT + IN_W;
  localparam logic [63:0] MUL_W  = (64'd1 << SHIFT) / 64'(DIV);
  localparam logic [IN_W:0] MUL  = MUL_W[IN_W:0];

  logic [PROD_W-1:0] prod;
  logic [IN_W-1:0]   q1_r;
  logic [IN_W-1:0]   x1_r;
  logic [IN_W-1:0]   qd2_r;
  logic [IN_W-1:0]   x2_r;
  logic [IN_W-1:0]   diff;
  logic [IN_W-1:0]   r_r;

  assign prod = PROD_W'(x) * PROD_W'(MUL);

  // Stage 1: quotient estimate
  always_ff @(posedge clk) begin
    if (en) begin
      q1_r <= prod[SHIFT +: IN_W];
      x1_r <= x;
    end
  end

  // Stage 2: quotient times divisor
  always_ff @(posedge clk) begin
    if (en) begin
      qd2_r <= IN_W'(32'(q1_r) * 32'(DIV));
      x2_r  <= x1_r;
    end
  end

  // Stage 3: remainder with one correction step
  assign diff = x2_r - qd2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (32'(diff) >= 32'(DIV)) begin
        r_r <= diff - IN_W'(DIV);
      end else begin
        r_r <= diff;
      end
    end
  end

  assign r = r_r;

endmodule

// File: rtl/text_mode_cell_buffer_with_scroll.sv
// Top level: text-mode cell store with hardware scroll offset.
//
// Holds ROWS x COLS character cells (glyph and attribute) in one single-port
// RAM. A write transaction either sets the scroll offset (address 0x3001,
// value taken modulo ROWS) or stores one cell at address modulo ROWS*COLS;
// a read transaction returns the glyph and expanded colors of view cell
// (view_row, view_col), showing logical row (view_row + scroll) mod ROWS.
// The pipeline takes one transaction per cycle while not stalled and returns
// read results in order; the depth is set by the input register, the
// reciprocal remainder units (3 stages), row/index formation (2 stages), the
// RAM read register and the output register. After reset, in_tready stays
// low while a clearing pass writes every cell to a space, bright white on
// black. Any output stall holds the whole pipeline.
module text_mode_cell_buffer_with_scroll #(
  parameter int ROWS         = tmcb_pkg::ROWS_DEF,
  parameter int COLS         = tmcb_pkg::COLS_DEF,
  parameter int VISIBLE_ROWS = tmcb_pkg::VISIBLE_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // bus_addr[15:0], bus_data[31:16], view_row[37:32], view_col[44:38], zero pad
  input  logic [47:0] in_tdata,
  // action[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // glyph[7:0], fg_red[15:8], fg_green[23:16], fg_blue[31:24],
  // bg_red[39:32], bg_green[47:40], bg_blue[55:48]
  output logic [55:0] out_tdata
);

  import tmcb_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int IDX_W = $clog2(CELLS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int SIDE_DEPTH = 4;

  typedef struct packed {
    logic        rd;
    logic        scr;
    logic        blank;
    logic [6:0]  col;
    logic [15:0] word;
  } side_t;

  // Input field views
  logic [15:0] in_addr;
  logic [15:0] in_data;
  logic [5:0]  in_vrow;
  logic [6:0]  in_vcol;

  assign in_addr = in_tdata[15:0];
  assign in_data = in_tdata[31:16];
  assign in_vrow = in_tdata[37:32];
  assign in_vcol = in_tdata[44:38];

  logic adv;
  logic accept;
  logic out_valid_r;
  logic [55:0] out_data_r;

  // Clearing pass after reset
  logic             clr_busy_r, clr_busy_nxt;
  logic [IDX_W-1:0] clr_addr_r, clr_addr_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + IDX_W'(1);
      if (clr_addr_r == IDX_W'(CELLS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Whole pipeline advances when the output register can move
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv && !clr_busy_r;
  assign accept    = in_tvalid && in_tready;

  // Decode of the incoming transaction
  side_t in_side;

  always_comb begin
    in_side.rd    = (in_tuser == ACT_READ);
    in_side.scr   = (in_tuser == ACT_WRITE) && (in_addr == SCROLL_ADDR);
    in_side.blank = ({1'b0, in_vrow} >= 7'(VISIBLE_ROWS)) || (in_vcol >= 7'(COLS));
    in_side.col   = in_vcol;
    in_side.word  = {in_data[15:8], clean_glyph(in_data[7:0])};
  end

  // Stage 0 input register and side pipe through the remainder units
  logic [SIDE_DEPTH-1:0] vld_r;
  side_t                 side_r [SIDE_DEPTH];
  logic [15:0]           addr0_r;
  logic [15:0]           data0_r;
  logic [5:0]            vrow0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[SIDE_DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (accept) begin
        side_r[0] <= in_side;
        addr0_r   <= in_addr;
        data0_r   <= in_data;
        vrow0_r   <= in_vrow;
      end
      for (int k = 1; k < SIDE_DEPTH; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Remainder units: cell index, view row, scroll value
  logic [15:0] addr_mod;
  logic [5:0]  vrow_mod;
  logic [15:0] scr_mod;

  tmcb_mod #(.IN_W(16), .DIV(CELLS)) u_addr_mod (
    .clk (clk),
    .en  (adv),
    .x   (addr0_r),
    .r   (addr_mod)
  );

  tmcb_mod #(.IN_W(6), .DIV(ROWS)) u_vrow_mod (
    .clk (clk),
    .en  (adv),
    .x   (vrow0_r),
    .r   (vrow_mod)
  );

  tmcb_mod #(.IN_W(16), .DIV(ROWS)) u_scr_mod (
    .clk (clk),
    .en  (adv),
    .x   (data0_r),
    .r   (scr_mod)
  );

  // Scroll register, updated in order with the reads that follow
  logic [ROW_W-1:0] scroll_r;
  side_t            side3;

  assign side3 = side_r[SIDE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_r <= '0;
    end else if (adv && vld_r[SIDE_DEPTH-1] && side3.scr) begin
      scroll_r <= scr_mod[ROW_W-1:0];
    end
  end

  // Stage 4: logical row of the view cell
  logic [ROW_W:0]   row_sum;
  logic [ROW_W-1:0] row_nxt;
  logic             vld4_r;
  side_t            side4_r;
  logic [ROW_W-1:0] row4_r;
  logic [IDX_W-1:0] widx4_r;

  assign row_sum = {1'b0, vrow_mod[ROW_W-1:0]} + {1'b0, scroll_r};

  always_comb begin
    if (row_sum >= (ROW_W+1)'(ROWS)) begin
      row_nxt = ROW_W'(row_sum - (ROW_W+1)'(ROWS));
    end else begin
      row_nxt = row_sum[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (adv) begin
      vld4_r <= vld_r[SIDE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side4_r <= side3;
      row4_r  <= row_nxt;
      widx4_r <= addr_mod[IDX_W-1:0];
    end
  end

  // Stage 5: RAM address and write data
  logic             we5_r;
  logic             rd5_r;
  logic             blank5_r;
  logic [IDX_W-1:0] idx5_r;
  logic [15:0]      word5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      we5_r <= 1'b0;
      rd5_r <= 1'b0;
    end else if (adv) begin
      we5_r <= vld4_r && !side4_r.rd && !side4_r.scr;
      rd5_r <= vld4_r && side4_r.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blank5_r <= side4_r.blank;
      word5_r  <= side4_r.word;
      if (side4_r.rd) begin
        idx5_r <= IDX_W'(32'(row4_r) * 32'(COLS) + 32'(side4_r.col));
      end else begin
        idx5_r <= widx4_r;
      end
    end
  end

  // Cell store: glyph in the low byte, attribute in the high byte
  logic             ram_en;
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [15:0]      ram_wdata;
  logic [15:0]      ram_rdata;

  always_comb begin
    if (clr_busy_r) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = clr_addr_r;
      ram_wdata = {RESET_ATTR, RESET_GLYPH};
    end else begin
      ram_en    = adv;
      ram_we    = we5_r;
      ram_addr  = idx5_r;
      ram_wdata = word5_r;
    end
  end

  tmcb_ram #(.WIDTH(16), .DEPTH(CELLS)) u_cells (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Stage 6: track the read alongside RAM read data
  logic rd6_r;
  logic blank6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd6_r <= 1'b0;
    end else if (adv) begin
      rd6_r <= rd5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blank6_r <= blank5_r;
    end
  end

  // Color expansion into the output register
  logic [55:0] out_nxt;
  logic [3:0]  fg_attr;
  logic [3:0]  bg_attr;

  assign fg_attr = ram_rdata[11:8];
  assign bg_attr = ram_rdata[15:12];

  always_comb begin
    if (blank6_r) begin
      out_nxt = '0;
    end else begin
      out_nxt = {level(bg_attr, ATTR_BLUE), level(bg_attr, ATTR_GREEN),
                 level(bg_attr, ATTR_RED), level(fg_attr, ATTR_BLUE),
                 level(fg_attr, ATTR_GREEN), level(fg_attr, ATTR_RED),
                 ram_rdata[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= rd6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: dv/cell_view_checker.sv
// Checker for the text-mode cell buffer: predicts each view cell read and compares.
module cell_view_checker #(
  parameter int ROWS         = tmcb_pkg::ROWS_DEF,
  parameter int COLS         = tmcb_pkg::COLS_DEF,
  parameter int VISIBLE_ROWS = tmcb_pkg::VISIBLE_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // bus_addr[15:0], bus_data[31:16], view_row[37:32], view_col[44:38], zero pad
  input  logic [47:0] in_tdata,
  // action[0]
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // glyph[7:0], fg_red[15:8], fg_green[23:16], fg_blue[31:24],
  // bg_red[39:32], bg_green[47:40], bg_blue[55:48]
  input  logic [55:0] out_tdata,
  output int          fail_count,
  output int          pending_views
);
  import tmcb_pkg::*;

  localparam int CELLS = ROWS * COLS;

  // One displayed cell, glyph in the low byte
  typedef struct packed {
    logic [7:0] bg_blue;
    logic [7:0] bg_green;
    logic [7:0] bg_red;
    logic [7:0] fg_blue;
    logic [7:0] fg_green;
    logic [7:0] fg_red;
    logic [7:0] glyph;
  } view_cell_t;

  // Shadow copy of the cell store and scroll pointer
  logic [7:0]  glyph_shadow [CELLS];
  logic [7:0]  attr_shadow  [CELLS];
  int unsigned scroll_row;
  view_cell_t  expected_views [$];

  initial begin
    fail_count    = 0;
    pending_views = 0;
  end

  // Expand one color bit of an attribute nibble
  function automatic logic [7:0] color_level(input logic [3:0] nib, input int comp);
    if (!nib[comp]) return LEVEL_OFF;
    return nib[ATTR_BRIGHT] ? LEVEL_BRIGHT : LEVEL_NORMAL;
  endfunction

  // Update the shadow store for a bus write
  task automatic apply_bus_write(input logic [15:0] addr, input logic [15:0] data);
    int unsigned row;
    int unsigned col;
    logic [7:0]  ch;
    if (addr == SCROLL_ADDR) begin
      scroll_row = data % ROWS;
    end else begin
      row = (addr / COLS) % ROWS;
      col = addr % COLS;
      ch  = data[7:0];
      if (ch < GLYPH_MIN || ch == GLYPH_INVALID) begin
        ch = GLYPH_EMPTY;
      end
      glyph_shadow[row * COLS + col] = ch;
      attr_shadow[row * COLS + col]  = data[15:8];
    end
  endtask

  // What the screen shows at (vrow, vcol) through the scroll pointer
  function automatic view_cell_t view_at(input logic [5:0] vrow, input logic [6:0] vcol);
    view_cell_t  v;
    int unsigned idx;
    logic [7:0]  a;
    v = '0;
    if (vrow < VISIBLE_ROWS && vcol < COLS) begin
      idx        = ((vrow + scroll_row) % ROWS) * COLS + vcol;
      a          = attr_shadow[idx];
      v.glyph    = glyph_shadow[idx];
      v.fg_red   = color_level(a[3:0], ATTR_RED);
      v.fg_green = color_level(a[3:0], ATTR_GREEN);
      v.fg_blue  = color_level(a[3:0], ATTR_BLUE);
      v.bg_red   = color_level(a[7:4], ATTR_RED);
      v.bg_green = color_level(a[7:4], ATTR_GREEN);
      v.bg_blue  = color_level(a[7:4], ATTR_BLUE);
    end
    return v;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    view_cell_t want;
    view_cell_t got;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        glyph_shadow[i] = RESET_GLYPH;
        attr_shadow[i]  = RESET_ATTR;
      end
      scroll_row = 0;
      expected_views.delete();
    end else begin
      // Result transaction: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        got = view_cell_t'(out_tdata);
        if (expected_views.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none actual %h", $time, out_tdata);
        end else begin
          want = expected_views.pop_front();
          check_field("glyph", want.glyph, got.glyph);
          check_field("fg_red", want.fg_red, got.fg_red);
          check_field("fg_green", want.fg_green, got.fg_green);
          check_field("fg_blue", want.fg_blue, got.fg_blue);
          check_field("bg_red", want.bg_red, got.bg_red);
          check_field("bg_green", want.bg_green, got.bg_green);
          check_field("bg_blue", want.bg_blue, got.bg_blue);
        end
      end
      // Input transaction: update the store or queue a predicted read
      if (in_tvalid && in_tready) begin
        if (in_tuser == ACT_WRITE) begin
          apply_bus_write(in_tdata[15:0], in_tdata[31:16]);
        end else begin
          expected_views.push_back(view_at(in_tdata[37:32], in_tdata[44:38]));
        end
      end
    end
    pending_views = expected_views.size();
  end

endmodule

// File: dv/text_mode_cell_buffer_with_scroll_test.sv
// Testbench top for the text-mode cell buffer: stimulus, flow control and verdict.
module text_mode_cell_buffer_with_scroll_test;
  import tmcb_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int QUIET_TAIL   = 150;
  localparam int PRESSURE_AT  = 500;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOT_ROWS     = 4;
  localparam int HOT_COLS     = 12;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  int          fail_count;
  int          pending_views;
  bit          quiet_tail;
  int unsigned cur_scroll;
  int          idle_cycles;

  text_mode_cell_buffer_with_scroll dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  cell_view_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending_views(pending_views)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Watchdog: too long without any accepted transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("text_mode_cell_buffer_with_scroll_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side back-pressure in random bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  // Drive one transaction from a falling edge; returns at the falling edge after it
  task automatic send_access(input logic act, input logic [15:0] addr,
                             input logic [15:0] data, input logic [5:0] vrow,
                             input logic [6:0] vcol);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {3'b000, vcol, vrow, data, addr};
    if (act == ACT_WRITE && addr == SCROLL_ADDR) begin
      cur_scroll = data % ROWS_DEF;
    end
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned lrow;
    int unsigned lcol;
    logic [15:0] data;
    quiet_tail  = 1'b0;
    cur_scroll  = 0;
    idle_cycles = 0;
    in_tvalid   = 1'b0;
    in_tuser    = ACT_WRITE;
    in_tdata    = '0;
    rst_n       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset contents, glyph blanking, address wrap, scroll, out-of-view reads
    send_access(ACT_READ, 16'h0000, 16'h0000, 6'd0, 7'd0);
    send_access(ACT_READ, 16'h0000, 16'h0000, 6'd47, 7'd105);
    send_access(ACT_WRITE, 16'h0000, 16'hFFFF, 6'd0, 7'd0);
    send_access(ACT_WRITE, 16'h0001, 16'h001F, 6'd0, 7'd0);
    send_access(ACT_WRITE, 16'h0002, 16'h7A20, 6'd0, 7'd0);
    send_access(ACT_WRITE, 16'h0003, 16'h86FE, 6'd0, 7'd0);
    send_access(ACT_WRITE, 16'd5087, 16'h9141, 6'd0, 7'd0);
    send_access(ACT_WRITE, 16'hFFFF, 16'h5A7E, 6'd63, 7'd127);
    send_access(ACT_READ, 16'h0000, 16'h0000, 6'd0, 7'd0);
    send_access(ACT_WRITE, 16'd5089, 16'h3C5B, 6'd0, 7'd0);
    send_access(ACT_READ, 16'h0000, 16'h0000, 6'd0, 7'd1);
    send_access(ACT_READ, 16'hFFFF, 16'hFFFF, 6'd0, 7'd2);
    send_access(ACT_READ, 16'h0000, 16'h0000, 6'd0, 7'd3);
    send_access(ACT_READ, 16'h0000, 16'h0000, 6'd42, 7'd27);
    send_access(ACT_WRITE, SCROLL_ADDR, 16'hFFFF, 6'd0, 7'd0);
    send_access(ACT_READ, 16'h0000, 16'h0000, 6'd33, 7'd1);
    send_access(ACT_READ, 16'h0000, 16'h0000, 6'd47, 7'd105);
    send_access(ACT_WRITE, SCROLL_ADDR, 16'd47, 6'd0, 7'd0);
    send_access(ACT_READ, 16'h0000, 16'h0000, 6'd1, 7'd3);
    send_access(ACT_READ, 16'h0000, 16'h0000, 6'd0, 7'd105);
    send_access(ACT_WRITE, SCROLL_ADDR, 16'd48, 6'd0, 7'd0);
    send_access(ACT_READ, 16'h0000, 16'h0000, 6'd48, 7'd0);
    send_access(ACT_READ, 16'h0000, 16'h0000, 6'd0, 7'd106);
    send_access(ACT_READ, 16'h0000, 16'h0000, 6'd63, 7'd127);

    // Random: writes and reads focused on a small hot region of the store
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_TAIL) quiet_tail = 1'b1;
      if (n == PRESSURE_AT) begin
        in_tvalid = 1'b0;
        while (pending_views != 0) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        data = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 47));
        send_access(ACT_WRITE, SCROLL_ADDR, data, 6'($urandom), 7'($urandom));
      end else if (pick < 42) begin
        data = 16'($urandom);
        case ($urandom_range(0, 5))
          0: data[7:0] = 8'($urandom_range(0, 31));
          1: data[7:0] = GLYPH_INVALID;
          default: ;
        endcase
        if ($urandom_range(0, 3) != 0) begin
          lrow = $urandom_range(0, HOT_ROWS - 1);
          lcol = $urandom_range(0, HOT_COLS - 1);
          send_access(ACT_WRITE, 16'(lrow * COLS_DEF + lcol), data, 6'($urandom),
                      7'($urandom));
        end else begin
          send_access(ACT_WRITE, 16'($urandom), data, 6'($urandom), 7'($urandom));
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          lrow = (($urandom_range(0, HOT_ROWS - 1) + ROWS_DEF) - cur_scroll) % ROWS_DEF;
          lcol = $urandom_range(0, HOT_COLS - 1);
        end else if (pick < 95) begin
          lrow = $urandom_range(0, VISIBLE_ROWS_DEF - 1);
          lcol = $urandom_range(0, COLS_DEF - 1);
        end else begin
          lrow = $urandom_range(0, 63);
          lcol = $urandom_range(0, 127);
        end
        send_access(ACT_READ, 16'($urandom), 16'($urandom), 6'(lrow), 7'(lcol));
      end
    end
    in_tvalid = 1'b0;

    // Drain outstanding reads, then let the pipeline settle
    while (pending_views != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_views == 0) begin
      $display("text_mode_cell_buffer_with_scroll_test passed");
    end else begin
      $display("text_mode_cell_buffer_with_scroll_test failed");
    end
    $finish;
  end

endmodule
